// ===== design/fcmac_pkg.sv =====
`default_nettype none

package fcmac_pkg;

    localparam int ROW_LANES  = 8;
    localparam int DATA_BITS  = 16;
    localparam int PROD_BITS  = 2 * DATA_BITS;
    localparam int SUM_BITS   = 48;
    localparam int PAIRS      = ROW_LANES / 2;
    localparam int PAIR_BITS  = $clog2(PAIRS);
    localparam int LANE_BITS  = $clog2(ROW_LANES);
    localparam int MAX_COLS   = 4096;
    localparam int COUNT_BITS = $clog2(MAX_COLS);
    localparam int COLS_BITS  = COUNT_BITS + 1;

    typedef logic signed [DATA_BITS-1:0] data_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [SUM_BITS-1:0]  sum_t;
    typedef logic [COLS_BITS-1:0]        cols_t;
    typedef logic [COUNT_BITS-1:0]       count_t;
    typedef logic [PAIR_BITS-1:0]        pair_t;
    typedef logic [LANE_BITS-1:0]        lane_t;

    typedef struct packed {
        data_t feature;
        data_t weight_0;
        data_t weight_1;
        data_t weight_2;
        data_t weight_3;
        data_t weight_4;
        data_t weight_5;
        data_t weight_6;
        data_t weight_7;
    } fcmac_in_t;

    typedef struct packed {
        sum_t  sum_even;
        sum_t  sum_odd;
        pair_t pair_index;
        logic  last;
    } fcmac_out_t;

    // travels alongside the data of each pipeline stage
    typedef struct packed {
        logic valid;
        logic tile_end;
    } stage_ctl_t;

endpackage

`default_nettype wire

// ===== design/fcmac_front.sv =====
`default_nettype none

module fcmac_front
    import fcmac_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire cols_t      cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire fcmac_in_t  in_item,
    input  wire logic       take,
    output data_t           feature,
    output data_t           weight [ROW_LANES],
    output stage_ctl_t      ctl
);

    cols_t      num_cols_reg;
    count_t     count_reg;
    count_t     count_next;
    stage_ctl_t ctl_reg;
    stage_ctl_t ctl_next;
    fcmac_in_t  item_reg;
    cols_t      eff_cols;
    cols_t      seen;
    logic       tile_end;
    logic       accept;

    assign in_stall = ctl_reg.valid && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        priority if (num_cols_reg == '0)
        begin
            eff_cols = cols_t'(1);
        end
        else if (num_cols_reg > cols_t'(MAX_COLS))
        begin
            eff_cols = cols_t'(MAX_COLS);
        end
        else
        begin
            eff_cols = num_cols_reg;
        end
    end

    assign seen       = cols_t'(count_reg) + cols_t'(1);
    assign tile_end   = (seen >= eff_cols);
    assign count_next = tile_end ? '0 : seen[COUNT_BITS-1:0];

    always_comb
    begin
        ctl_next = ctl_reg;
        if (accept)
        begin
            ctl_next.valid    = 1'b1;
            ctl_next.tile_end = tile_end;
        end
        else if (take)
        begin
            ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= cols_t'(1);
            count_reg    <= '0;
            ctl_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                num_cols_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign feature   = item_reg.feature;
    assign weight[0] = item_reg.weight_0;
    assign weight[1] = item_reg.weight_1;
    assign weight[2] = item_reg.weight_2;
    assign weight[3] = item_reg.weight_3;
    assign weight[4] = item_reg.weight_4;
    assign weight[5] = item_reg.weight_5;
    assign weight[6] = item_reg.weight_6;
    assign weight[7] = item_reg.weight_7;
    assign ctl       = ctl_reg;

endmodule

`default_nettype wire

// ===== design/fcmac_mul.sv =====
`default_nettype none

module fcmac_mul
    import fcmac_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire stage_ctl_t ctl_in,
    input  wire data_t      feature,
    input  wire data_t      weight [ROW_LANES],
    input  wire logic       take_out,
    output logic            take_in,
    output stage_ctl_t      ctl_out,
    output prod_t           prod [ROW_LANES]
);

    stage_ctl_t ctl_reg;
    prod_t      prod_reg  [ROW_LANES];
    prod_t      prod_next [ROW_LANES];

    assign take_in = !ctl_reg.valid || take_out;

    always_comb
    begin
        for (int i = 0; i < ROW_LANES; i++)
        begin
            prod_next[i] = prod_t'(feature) * prod_t'(weight[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (take_in)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in && ctl_in.valid)
        begin
            for (int i = 0; i < ROW_LANES; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign prod    = prod_reg;

endmodule

`default_nettype wire

// ===== design/fcmac_accum.sv =====
`default_nettype none

module fcmac_accum
    import fcmac_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire stage_ctl_t ctl,
    input  wire prod_t      prod [ROW_LANES],
    output logic            take,
    output logic            out_valid,
    input  wire logic       out_stall,
    output fcmac_out_t      out_item
);

    sum_t  acc_reg  [ROW_LANES];
    sum_t  sum_new  [ROW_LANES];
    sum_t  bank_reg [ROW_LANES];
    logic  bank_valid_reg;
    pair_t pair_reg;
    logic  step;
    logic  last_pair;
    logic  out_done;

    // a tile end waits here while the previous tile is still being sent
    assign take = !ctl.valid || !ctl.tile_end || !bank_valid_reg;
    assign step = ctl.valid && take;

    always_comb
    begin
        for (int i = 0; i < ROW_LANES; i++)
        begin
            sum_new[i] = acc_reg[i] + SUM_BITS'(prod[i]);
        end
    end

    assign last_pair = (pair_reg == pair_t'(PAIRS - 1));
    assign out_done  = bank_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROW_LANES; i++)
            begin
                acc_reg[i] <= '0;
            end
            bank_valid_reg <= 1'b0;
            pair_reg       <= '0;
        end
        else
        begin
            if (step)
            begin
                for (int i = 0; i < ROW_LANES; i++)
                begin
                    acc_reg[i] <= ctl.tile_end ? '0 : sum_new[i];
                end
            end
            if (step && ctl.tile_end)
            begin
                bank_valid_reg <= 1'b1;
                pair_reg       <= '0;
            end
            else if (out_done)
            begin
                if (last_pair)
                begin
                    bank_valid_reg <= 1'b0;
                    pair_reg       <= '0;
                end
                else
                begin
                    pair_reg <= pair_reg + pair_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && ctl.tile_end)
        begin
            for (int i = 0; i < ROW_LANES; i++)
            begin
                bank_reg[i] <= sum_new[i];
            end
        end
    end

    assign out_valid           = bank_valid_reg;
    assign out_item.sum_even   = bank_reg[lane_t'({pair_reg, 1'b0})];
    assign out_item.sum_odd    = bank_reg[lane_t'({pair_reg, 1'b1})];
    assign out_item.pair_index = pair_reg;
    assign out_item.last       = last_pair;

endmodule

`default_nettype wire

// ===== design/fc_layer_mac_tile_core.sv =====
`default_nettype none

// Output tile of a fully connected layer. Each input transaction carries one
// feature value and eight signed Q8.8 weights; eight lanes multiply and add
// the full Q16.16 products into 48-bit wrapping accumulators. One column is
// taken every clock while in_stall is low; a column passes through the input
// register and the product register to the accumulators. When a tile's
// num_cols columns are in (0 counts as 1, above 4096 as 4096) the sums move to
// an output bank and the accumulators clear, so the next tile starts at once.
// The bank sends four result transactions, one row pair per cycle while
// out_stall is low, the last marked. A tile-ending column is held in the
// product stage while the previous tile's bank is still being sent, so with
// num_cols of 5 or more the input never stalls on its own account.
// num_cols may be written only while the block is idle.
module fc_layer_mac_tile_core
    import fcmac_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_write,
    input  wire cols_t     cfg_data,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire fcmac_in_t in_item,
    output logic           out_valid,
    input  wire logic      out_stall,
    output fcmac_out_t     out_item
);

    data_t      feature;
    data_t      weight [ROW_LANES];
    stage_ctl_t front_ctl;
    stage_ctl_t mul_ctl;
    prod_t      prod [ROW_LANES];
    logic       mul_take;
    logic       acc_take;

    fcmac_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .take      (mul_take),
        .feature   (feature),
        .weight    (weight),
        .ctl       (front_ctl)
    );

    fcmac_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (front_ctl),
        .feature  (feature),
        .weight   (weight),
        .take_out (acc_take),
        .take_in  (mul_take),
        .ctl_out  (mul_ctl),
        .prod     (prod)
    );

    fcmac_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mul_ctl),
        .prod      (prod),
        .take      (acc_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire
